FILE: hdl/ffra_pkg.sv
// Shared types and constants of the first-fit region allocator.
package ffra_pkg;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int unsigned PADDR_W          = 3;
  localparam logic        REG_REGION_BYTES = 1'b0;
  localparam logic [31:0] REGION_RESET     = 32'd65536;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] request_size;
    logic [31:0] target_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_offset;
  } rsp_t;

endpackage

FILE: hdl/first_fit_region_allocator_unit.sv
// Top level of the first-fit region allocator: sequencer, entry memory, result register.
//
// Usage: one request channel (in_valid_i / in_stall_o / in_data_i) carries an
// opcode (allocate, free by offset, clear), a request size and a target offset.
// One response per request comes out on out_valid_o / out_stall_i / out_data_o
// with a status and, for a successful allocate, the granted offset.
// The region size is set through the APB port (register 0, byte address 0).
// The allocation table lives in a single-port-write memory of MAX_ENTRIES words
// with a registered read; one 34-bit adder/comparator is shared by the fit scan.
// Steps per request: allocate tests the gap before each entry in turn and then
// before the region end, advancing past entries that leave no room; it then moves
// later entries up one slot and writes the new entry, or reports no fit. Free
// compares entries against the target offset, then moves later entries down one
// slot; a miss reports not found. Clear, table full, free of an empty table and
// an unused opcode go straight to the response.
// One request at a time: the next one can transfer in the cycle after the
// response is loaded. in_stall_o is high while a request is in flight.
// Reset empties the table (entry count to zero, no memory sweep) and loads the
// region size with 65536. A stalled response holds in the output register; the
// next request may already transfer, and its response waits until the register frees.
module first_fit_region_allocator_unit #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ffra_pkg::req_t               in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ffra_pkg::rsp_t               out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffra_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned IDXW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNTW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIT,
    S_ADV,
    S_INS_RD,
    S_INS_WR,
    S_FR_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_RESP
  } state_e;

  logic [31:0] region_bytes;

  ffra_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .region_bytes_o (region_bytes)
  );

  // Sequencer registers.
  state_e         state_q, state_d;
  logic [CNTW-1:0] count_q, count_d;
  logic [IDXW-1:0] idx_q, idx_d;     // scan position
  logic [IDXW-1:0] pos_q, pos_d;     // move position
  logic [32:0]     cur_q, cur_d;     // end of the previous entry, may pass 2^32
  logic [31:0]     want_q, want_d;
  logic [31:0]     where_q, where_d;
  ffra_pkg::rsp_t  res_q, res_d;
  logic            out_valid_q, out_valid_d;
  ffra_pkg::rsp_t  out_data_q, out_data_d;

  // Entry memory: {start, length} per word.
  logic [63:0]     mem_q [MAX_ENTRIES];
  logic [63:0]     rd_data_q;
  logic [IDXW-1:0] rd_addr;
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  logic [63:0]     mem_wdata;

  logic [31:0] rd_start;
  logic [31:0] rd_len;
  assign rd_start = rd_data_q[63:32];
  assign rd_len   = rd_data_q[31:0];

  // Shared adder and compare.
  logic [33:0] add_a, add_b, add_sum;
  logic [31:0] limit;
  logic        at_end;
  logic        fits;
  logic        in_xfer;

  assign add_sum = add_a + add_b;
  assign at_end  = (CNTW'(idx_q) == count_q);
  assign limit   = at_end ? region_bytes : rd_start;
  assign fits    = ({2'b00, limit} >= add_sum);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    want_d      = want_q;
    where_d     = where_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    rd_addr     = idx_q;           // reread the scanned entry by default
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = rd_data_q;
    add_a       = {1'b0, cur_q};
    add_b       = {2'b00, want_q};

    // Drain the output register when the receiver takes the response.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          want_d  = in_data_i.request_size;
          where_d = in_data_i.target_offset;
          res_d   = '{status: ffra_pkg::ST_OK, granted_offset: 32'd0};
          idx_d   = '0;
          cur_d   = '0;
          rd_addr = '0;
          case (in_data_i.opcode)
            ffra_pkg::OP_ALLOC: begin
              if (count_q == CNT_MAX) begin
                res_d.status = ffra_pkg::ST_FULL;
                state_d      = S_RESP;
              end else begin
                state_d = S_FIT;
              end
            end
            ffra_pkg::OP_FREE: begin
              if (count_q == '0) begin
                res_d.status = ffra_pkg::ST_NOTFOUND;
                state_d      = S_RESP;
              end else begin
                state_d = S_FR_CMP;
              end
            end
            ffra_pkg::OP_CLEAR: begin
              count_d = '0;
              state_d = S_RESP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      // Test the gap before entry idx (or before the region end).
      S_FIT: begin
        if (fits) begin
          res_d.granted_offset = cur_q[31:0];
          pos_d                = count_q[IDXW-1:0];
          state_d              = S_INS_RD;
        end else if (at_end) begin
          res_d.status = ffra_pkg::ST_NOFIT;
          state_d      = S_RESP;
        end else begin
          state_d = S_ADV;
        end
      end

      // Advance the cursor past entry idx and fetch the next entry.
      S_ADV: begin
        add_a   = {2'b00, rd_start};
        add_b   = {2'b00, rd_len};
        cur_d   = add_sum[32:0];
        idx_d   = idx_q + IDXW'(1);
        rd_addr = idx_q + IDXW'(1);
        state_d = S_FIT;
      end

      // Move entries up one slot, then drop the new entry into the gap.
      S_INS_RD: begin
        if (pos_q == idx_q) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = {cur_q[31:0], want_q};
          count_d   = count_q + CNTW'(1);
          state_d   = S_RESP;
        end else begin
          rd_addr = pos_q - IDXW'(1);
          state_d = S_INS_WR;
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        pos_d     = pos_q - IDXW'(1);
        state_d   = S_INS_RD;
      end

      // Search for the lowest-indexed entry with the target start.
      S_FR_CMP: begin
        if (rd_start == where_q) begin
          pos_d   = idx_q;
          state_d = S_DEL_RD;
        end else if (CNTW'(idx_q) + CNTW'(1) == count_q) begin
          res_d.status = ffra_pkg::ST_NOTFOUND;
          state_d      = S_RESP;
        end else begin
          idx_d   = idx_q + IDXW'(1);
          rd_addr = idx_q + IDXW'(1);
        end
      end

      // Close the hole: move later entries down one slot.
      S_DEL_RD: begin
        if (CNTW'(pos_q) + CNTW'(1) == count_q) begin
          count_d = count_q - CNTW'(1);
          state_d = S_RESP;
        end else begin
          rd_addr = pos_q + IDXW'(1);
          state_d = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        pos_d     = pos_q + IDXW'(1);
        state_d   = S_DEL_RD;
      end

      // Hand the response to the output register once it is free.
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    cur_q      <= cur_d;
    want_q     <= want_d;
    where_q    <= where_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A transferred request keeps the block busy in the following cycle.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("request channel open right after a transfer");

  // The table never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("entry count above table depth");

  // Only a successful allocate reports a nonzero offset.
  a_offset_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ffra_pkg::ST_OK))
      |-> (out_data_o.granted_offset == 32'd0))
    else $error("offset reported with a failing status");

  // A response leaves the sequencer only from the response state.
  a_resp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && out_valid_d) |-> (state_q == S_RESP))
    else $error("response loaded outside the response state");

endmodule

FILE: hdl/ffra_cfg.sv
// APB register file of the allocator: holds the region size register.
module ffra_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffra_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [31:0]                  region_bytes_o
);

  logic [31:0] region_q;
  logic        hit_region;

  assign pready     = 1'b1;
  assign hit_region = (paddr[2] == ffra_pkg::REG_REGION_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= ffra_pkg::REGION_RESET;
    end else if (psel && penable && pwrite && pready && hit_region) begin
      region_q <= pwdata;
    end
  end

  assign prdata         = hit_region ? region_q : 32'd0;
  assign region_bytes_o = region_q;

endmodule
